FILE: hdl/tsa_pkg.sv
// Shared types and constants for the triangle strip assembly block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package tsa_pkg;

    localparam int INDEX_W = 16;
    localparam int BYTE_W = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = 1;
    localparam int QUEUE_CW = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_WIDTH_MODE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_LIMIT = 8'd1;

    localparam logic [STATUS_W-1:0] STATUS_PRIMING = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMITTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DEGENERATE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE = 2'd3;

    localparam logic [INDEX_W-1:0] VERTEX_LIMIT_RESET = 16'hFFFF;
    localparam logic [INDEX_W-1:0] SEEN_MAX = 16'hFFFF;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               last;
        logic               drop;
    } t_idx_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage
`default_nettype wire

FILE: hdl/tsa_front.sv
// Byte assembler: accepts raw index bytes and builds completed indices.
// Depends on tsa_pkg; pushes completed indices into tsa_queue.
`timescale 1ns / 1ps
`default_nettype none
module tsa_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_mode,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [tsa_pkg::BYTE_W-1:0]    i_index_byte,
    input  wire logic                          i_strip_end,
    input  wire tsa_pkg::t_queue_status        i_queue_status,
    output logic                               o_push,
    output tsa_pkg::t_idx_item                 o_item
);

    logic                       r_phase;
    logic                       n_phase;
    logic [tsa_pkg::BYTE_W-1:0] r_hold;
    logic [tsa_pkg::BYTE_W-1:0] n_hold;
    logic                       accept;

    assign o_stall = i_queue_status.full;
    assign accept = i_valid && !o_stall;
    assign o_push = accept && (i_mode || r_phase || i_strip_end);
    assign o_item.index = i_mode ? {{(tsa_pkg::INDEX_W - tsa_pkg::BYTE_W){1'b0}}, i_index_byte}
                                 : {r_hold, i_index_byte};
    assign o_item.last = i_strip_end;
    assign o_item.drop = !i_mode && !r_phase;

    always_comb begin
        n_phase = r_phase;
        n_hold = r_hold;
        if (accept) begin
            if (!i_mode && !r_phase && !i_strip_end) begin
                n_phase = 1'b1;
                n_hold = i_index_byte;
            end else begin
                n_phase = 1'b0;
                n_hold = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_hold <= '0;
        end else begin
            r_phase <= n_phase;
            r_hold <= n_hold;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/tsa_queue.sv
// Two-entry queue of completed indices between the assembler and the back end.
// Depends on tsa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tsa_queue (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire tsa_pkg::t_idx_item     i_item,
    input  wire logic                   i_pop,
    output tsa_pkg::t_idx_item          o_item,
    output tsa_pkg::t_queue_status      o_status
);

    tsa_pkg::t_idx_item           r_mem [tsa_pkg::QUEUE_DEPTH];
    logic [tsa_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [tsa_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [tsa_pkg::QUEUE_CW-1:0] r_count;
    logic [tsa_pkg::QUEUE_CW-1:0] n_count;

    assign o_status.empty = (r_count == '0);
    assign o_status.full = (r_count == tsa_pkg::QUEUE_CW'(tsa_pkg::QUEUE_DEPTH));
    assign o_item = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tsa_pkg::QUEUE_CW'(tsa_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: hdl/tsa_back.sv
// Triangle builder: keeps the index window, classifies triangles and holds
// the result register. Depends on tsa_pkg; pops items from tsa_queue.
`timescale 1ns / 1ps
`default_nettype none
module tsa_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [tsa_pkg::INDEX_W-1:0]   i_vertex_limit,
    input  wire tsa_pkg::t_queue_status        i_queue_status,
    input  wire tsa_pkg::t_idx_item            i_item,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [tsa_pkg::STATUS_W-1:0]       o_status,
    output logic [tsa_pkg::INDEX_W-1:0]        o_corner_a,
    output logic [tsa_pkg::INDEX_W-1:0]        o_corner_b,
    output logic [tsa_pkg::INDEX_W-1:0]        o_corner_c,
    output logic                               o_strip_last
);

    logic [tsa_pkg::INDEX_W-1:0]  r_older;
    logic [tsa_pkg::INDEX_W-1:0]  r_newer;
    logic [tsa_pkg::INDEX_W-1:0]  r_seen;
    logic                         r_valid;
    logic [tsa_pkg::STATUS_W-1:0] r_status;
    logic [tsa_pkg::INDEX_W-1:0]  r_corner_a;
    logic [tsa_pkg::INDEX_W-1:0]  r_corner_b;
    logic [tsa_pkg::INDEX_W-1:0]  r_corner_c;
    logic                         r_last;

    logic [tsa_pkg::STATUS_W-1:0] n_status;
    logic [tsa_pkg::INDEX_W-1:0]  n_corner_a;
    logic [tsa_pkg::INDEX_W-1:0]  n_corner_b;
    logic [tsa_pkg::INDEX_W-1:0]  n_corner_c;
    logic                         primed;
    logic                         out_free;

    assign out_free = !r_valid || !i_stall;
    assign o_pop = !i_queue_status.empty && out_free;
    assign primed = (r_seen >= tsa_pkg::INDEX_W'(2));

    always_comb begin
        n_status = tsa_pkg::STATUS_PRIMING;
        n_corner_a = '0;
        n_corner_b = '0;
        n_corner_c = '0;
        if (primed) begin
            n_corner_a = r_older;
            n_corner_b = r_seen[0] ? i_item.index : r_newer;
            n_corner_c = r_seen[0] ? r_newer : i_item.index;
            if ((n_corner_a == n_corner_b) || (n_corner_b == n_corner_c)
                    || (n_corner_a == n_corner_c)) begin
                n_status = tsa_pkg::STATUS_DEGENERATE;
            end else if ((n_corner_a >= i_vertex_limit) || (n_corner_b >= i_vertex_limit)
                    || (n_corner_c >= i_vertex_limit)) begin
                n_status = tsa_pkg::STATUS_OUT_OF_RANGE;
            end else begin
                n_status = tsa_pkg::STATUS_EMITTED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_item.drop) begin
            r_status <= n_status;
            r_corner_a <= n_corner_a;
            r_corner_b <= n_corner_b;
            r_corner_c <= n_corner_c;
            r_last <= i_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older <= '0;
            r_newer <= '0;
            r_seen <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop && !i_item.drop) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_item.last) begin
                    r_older <= '0;
                    r_newer <= '0;
                    r_seen <= '0;
                end else begin
                    r_older <= r_newer;
                    r_newer <= i_item.index;
                    if (r_seen != tsa_pkg::SEEN_MAX) begin
                        r_seen <= r_seen + 1'b1;
                    end
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_corner_a = r_corner_a;
    assign o_corner_b = r_corner_b;
    assign o_corner_c = r_corner_c;
    assign o_strip_last = r_last;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.last) |=> (r_seen == '0))
        else $error("strip end did not clear the window");
    a_pop_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |-> !o_pop)
        else $error("result overwritten while stalled");
    a_priming_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_item.drop && !primed) |=> (r_status == tsa_pkg::STATUS_PRIMING))
        else $error("priming index gave a triangle status");

endmodule
`default_nettype wire

FILE: hdl/triangle_strip_assembly_core.sv
// Top level of the triangle strip assembly block: configuration registers,
// byte assembler, index queue and triangle builder.
// Depends on tsa_pkg, tsa_front, tsa_queue and tsa_back.
//
// The input channel (i_valid, o_stall) carries one index byte per item with
// its strip end flag. The output channel (o_valid, i_stall) carries one status
// item per completed index: status, three corners and the strip end flag.
// The configuration channel (i_cfg_valid, o_cfg_ready) writes index width mode
// at index 0 and vertex limit at index 1; other indices are ignored. It is
// always ready and should only be used while the block is idle.
// Throughput is one byte per cycle while o_stall is low. A byte that completes
// an index is written into the two-entry queue when it is accepted, and the
// output register loads its result from the queue once that register is free.
// A strip end on a lone high byte passes the queue to clear the window and
// gives no result.
// When the receiver stalls, the output register holds, the queue fills and
// o_stall rises once both queue entries are occupied.
// Reset clears the window, counters and queue and restores 16-bit mode and a
// vertex limit of 65535.
`timescale 1ns / 1ps
`default_nettype none
module triangle_strip_assembly_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [tsa_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [tsa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [tsa_pkg::BYTE_W-1:0]        i_index_byte,
    input  wire logic                              i_strip_end,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [tsa_pkg::STATUS_W-1:0]           o_status,
    output logic [tsa_pkg::INDEX_W-1:0]            o_corner_a,
    output logic [tsa_pkg::INDEX_W-1:0]            o_corner_b,
    output logic [tsa_pkg::INDEX_W-1:0]            o_corner_c,
    output logic                                   o_strip_last
);

    logic                        r_mode;
    logic [tsa_pkg::INDEX_W-1:0] r_vertex_limit;
    logic                        push;
    logic                        pop;
    tsa_pkg::t_idx_item          push_item;
    tsa_pkg::t_idx_item          head_item;
    tsa_pkg::t_queue_status      queue_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_vertex_limit <= tsa_pkg::VERTEX_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == tsa_pkg::CFG_INDEX_WIDTH_MODE) begin
                r_mode <= i_cfg_data[0];
            end else if (i_cfg_index == tsa_pkg::CFG_VERTEX_LIMIT) begin
                r_vertex_limit <= i_cfg_data[tsa_pkg::INDEX_W-1:0];
            end
        end
    end

    tsa_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (r_mode),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_index_byte   (i_index_byte),
        .i_strip_end    (i_strip_end),
        .i_queue_status (queue_status),
        .o_push         (push),
        .o_item         (push_item)
    );

    tsa_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (queue_status)
    );

    tsa_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vertex_limit (r_vertex_limit),
        .i_queue_status (queue_status),
        .i_item         (head_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_corner_a     (o_corner_a),
        .o_corner_b     (o_corner_b),
        .o_corner_c     (o_corner_c),
        .o_strip_last   (o_strip_last)
    );

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench for triangle_strip_assembly_core: directed strips, then random
// strips under several handshake pressure phases, checked against a behavioral predictor.
// Depends on tsa_pkg and triangle_strip_assembly_core.
`timescale 1ns / 1ps
module tb_top;

    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_STRIP_LEN = 60;
    localparam int SEGMENT_BYTES = 200;

    typedef struct packed {
        logic [tsa_pkg::STATUS_W-1:0] status;
        logic [tsa_pkg::INDEX_W-1:0]  corner_a;
        logic [tsa_pkg::INDEX_W-1:0]  corner_b;
        logic [tsa_pkg::INDEX_W-1:0]  corner_c;
        logic                         last;
    } t_tri_result;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [tsa_pkg::CFG_INDEX_W-1:0]  i_cfg_index;
    logic [tsa_pkg::CFG_DATA_W-1:0]   i_cfg_data;
    logic                             i_valid;
    logic                             o_stall;
    logic [tsa_pkg::BYTE_W-1:0]       i_index_byte;
    logic                             i_strip_end;
    logic                             o_valid;
    logic                             i_stall;
    logic [tsa_pkg::STATUS_W-1:0]     o_status;
    logic [tsa_pkg::INDEX_W-1:0]      o_corner_a;
    logic [tsa_pkg::INDEX_W-1:0]      o_corner_b;
    logic [tsa_pkg::INDEX_W-1:0]      o_corner_c;
    logic                             o_strip_last;

    // Predictor state and its copy of the registers.
    logic                             cfg_8bit = 1'b0;
    logic [tsa_pkg::INDEX_W-1:0]      cfg_vlimit = tsa_pkg::VERTEX_LIMIT_RESET;
    logic [tsa_pkg::INDEX_W-1:0]      win_older = '0;
    logic [tsa_pkg::INDEX_W-1:0]      win_newer = '0;
    logic [tsa_pkg::INDEX_W-1:0]      seen_cnt = '0;
    logic [tsa_pkg::BYTE_W-1:0]       held_high = '0;
    logic                             want_low = 1'b0;

    t_tri_result            pending_tris[$];
    int                     error_count = 0;
    int                     bytes_taken = 0;
    int                     status_count[4] = '{0, 0, 0, 0};
    int                     send_idle_pct = 0;
    int                     stall_pct = 0;

    triangle_strip_assembly_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_index_byte (i_index_byte),
        .i_strip_end  (i_strip_end),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_corner_a   (o_corner_a),
        .o_corner_b   (o_corner_b),
        .o_corner_c   (o_corner_c),
        .o_strip_last (o_strip_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        error_count++;
        if (error_count <= 30) begin
            $display("MISMATCH at %0t ns: %s, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    task automatic clear_window();
        win_older = '0;
        win_newer = '0;
        seen_cnt = '0;
        held_high = '0;
        want_low = 1'b0;
    endtask

    task automatic assemble_byte(input logic [tsa_pkg::BYTE_W-1:0] b, input logic last);
        logic [tsa_pkg::INDEX_W-1:0] idx;
        t_tri_result                 r;
        if (!cfg_8bit && !want_low) begin
            held_high = b;
            want_low = 1'b1;
            if (last) begin
                clear_window();
            end
        end else begin
            idx = cfg_8bit ? {8'h00, b} : {held_high, b};
            want_low = 1'b0;
            held_high = '0;
            r = '0;
            r.status = tsa_pkg::STATUS_PRIMING;
            r.last = last;
            if (seen_cnt >= 2) begin
                r.corner_a = win_older;
                r.corner_b = seen_cnt[0] ? idx : win_newer;
                r.corner_c = seen_cnt[0] ? win_newer : idx;
                if (r.corner_a == r.corner_b || r.corner_b == r.corner_c ||
                    r.corner_a == r.corner_c) begin
                    r.status = tsa_pkg::STATUS_DEGENERATE;
                end else if (r.corner_a >= cfg_vlimit || r.corner_b >= cfg_vlimit ||
                             r.corner_c >= cfg_vlimit) begin
                    r.status = tsa_pkg::STATUS_OUT_OF_RANGE;
                end else begin
                    r.status = tsa_pkg::STATUS_EMITTED;
                end
            end
            win_older = win_newer;
            win_newer = idx;
            if (seen_cnt != tsa_pkg::SEEN_MAX) begin
                seen_cnt++;
            end
            if (last) begin
                clear_window();
            end
            pending_tris.push_back(r);
        end
    endtask

    task automatic check_result();
        t_tri_result want;
        if (pending_tris.size() == 0) begin
            report_mismatch("status item with nothing expected", 0, o_status);
        end else begin
            want = pending_tris.pop_front();
            status_count[o_status]++;
            if (o_status !== want.status) begin
                report_mismatch("status", want.status, o_status);
            end
            if (o_corner_a !== want.corner_a) begin
                report_mismatch("corner_a", want.corner_a, o_corner_a);
            end
            if (o_corner_b !== want.corner_b) begin
                report_mismatch("corner_b", want.corner_b, o_corner_b);
            end
            if (o_corner_c !== want.corner_c) begin
                report_mismatch("corner_c", want.corner_c, o_corner_c);
            end
            if (o_strip_last !== want.last) begin
                report_mismatch("strip_last", want.last, o_strip_last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == tsa_pkg::CFG_INDEX_WIDTH_MODE) begin
                    cfg_8bit = i_cfg_data[0];
                end else if (i_cfg_index == tsa_pkg::CFG_VERTEX_LIMIT) begin
                    cfg_vlimit = i_cfg_data;
                end
            end
            if (i_valid && !o_stall) begin
                bytes_taken++;
                assemble_byte(i_index_byte, i_strip_end);
            end
            if (o_valid && !i_stall) begin
                check_result();
            end
        end
    end

    task automatic send_item(input logic [tsa_pkg::BYTE_W-1:0] b, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_index_byte <= b;
        i_strip_end <= last;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_index(input logic [tsa_pkg::INDEX_W-1:0] idx, input logic last);
        if (!cfg_8bit) begin
            send_item(idx[15:8], 1'b0);
        end
        send_item(idx[7:0], last);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_tris.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tsa_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [tsa_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Reset values: 16-bit indices, vertex limit 65535.
    task automatic test_priming_and_swap();
        send_index(16'h0000, 1'b0);
        send_index(16'hABCD, 1'b0);
        send_index(16'h00FF, 1'b0);
        send_index(16'hFFFF, 1'b0);
        send_index(16'h8001, 1'b1);
        wait_idle();
    endtask

    // A triangle that is both degenerate and out of range must report degenerate.
    task automatic test_degenerate_and_range();
        write_reg(tsa_pkg::CFG_INDEX_WIDTH_MODE, 16'd1);
        write_reg(tsa_pkg::CFG_VERTEX_LIMIT, 16'd10);
        send_index(16'd1, 1'b0);
        send_index(16'd2, 1'b0);
        send_index(16'd1, 1'b0);
        send_index(16'd3, 1'b0);
        send_index(16'd3, 1'b0);
        send_index(16'd200, 1'b0);
        send_index(16'd9, 1'b1);
        wait_idle();
    endtask

    task automatic test_half_index_end();
        write_reg(tsa_pkg::CFG_INDEX_WIDTH_MODE, 16'd0);
        write_reg(tsa_pkg::CFG_VERTEX_LIMIT, tsa_pkg::VERTEX_LIMIT_RESET);
        send_index(16'h0102, 1'b0);
        send_item(8'h55, 1'b1);
        send_index(16'h0304, 1'b0);
        wait_idle();
    endtask

    // A high byte is left held when the width changes to 8 bits.
    task automatic test_mode_change();
        send_item(8'hAA, 1'b0);
        wait_idle();
        write_reg(tsa_pkg::CFG_INDEX_WIDTH_MODE, 16'd1);
        send_index(16'd7, 1'b0);
        send_index(16'd8, 1'b0);
        send_index(16'd9, 1'b1);
        wait_idle();
    endtask

    task automatic test_register_decode();
        write_reg(8'd2, 16'h0000);
        write_reg(8'hFF, 16'hFFFF);
        write_reg(tsa_pkg::CFG_INDEX_WIDTH_MODE, 16'hFFFE);
        write_reg(tsa_pkg::CFG_VERTEX_LIMIT, 16'd0);
        send_index(16'h0000, 1'b0);
        send_index(16'hFFFF, 1'b0);
        send_index(16'h0001, 1'b1);
        wait_idle();
    endtask

    task automatic test_long_strip();
        write_reg(tsa_pkg::CFG_INDEX_WIDTH_MODE, 16'h0003);
        write_reg(tsa_pkg::CFG_VERTEX_LIMIT, tsa_pkg::VERTEX_LIMIT_RESET);
        for (int k = 0; k < LONG_STRIP_LEN; k++) begin
            send_item(8'($urandom), k == LONG_STRIP_LEN - 1);
        end
        wait_idle();
    endtask

    task automatic run_random_segment(input int n_bytes);
        int                          sent;
        int                          len;
        int                          k;
        logic                        ended;
        logic [tsa_pkg::INDEX_W-1:0] lim;
        logic [tsa_pkg::INDEX_W-1:0] base;
        logic [tsa_pkg::INDEX_W-1:0] idx;
        write_reg(tsa_pkg::CFG_INDEX_WIDTH_MODE, 16'($urandom));
        case ($urandom_range(5))
            0: lim = 16'd0;
            1: lim = tsa_pkg::VERTEX_LIMIT_RESET;
            2: lim = 16'($urandom_range(1, 16));
            3: lim = 16'd255;
            default: lim = 16'($urandom);
        endcase
        write_reg(tsa_pkg::CFG_VERTEX_LIMIT, lim);
        sent = 0;
        while (sent < n_bytes) begin
            len = $urandom_range(1, 12);
            base = 16'($urandom_range(0, cfg_8bit ? 250 : 65530));
            if (lim > 8 && base >= lim) begin
                base = 16'($urandom_range(0, lim - 8));
            end
            ended = 1'b0;
            k = 0;
            while (!ended) begin
                if (!cfg_8bit && $urandom_range(15) == 0) begin
                    send_item(8'($urandom), 1'b1);
                    sent++;
                    ended = 1'b1;
                end else begin
                    case ($urandom_range(9))
                        0: idx = 16'($urandom);
                        1: idx = lim + 16'($urandom_range(0, 2));
                        default: idx = base + 16'($urandom_range(0, 5));
                    endcase
                    k++;
                    ended = (k == len);
                    send_index(idx, ended);
                    sent += cfg_8bit ? 1 : 2;
                end
            end
        end
        // Sometimes leave a high byte held across the next register write.
        if (!cfg_8bit && $urandom_range(2) == 0) begin
            send_item(8'($urandom), 1'b0);
        end
        wait_idle();
    endtask

    task automatic test_random_strips();
        int idle_set[4] = '{0, 73, 0, 21};
        int stall_set[4] = '{0, 0, 73, 21};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            run_random_segment(SEGMENT_BYTES);
            run_random_segment(SEGMENT_BYTES);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_index_byte = '0;
        i_strip_end = 1'b0;
        i_stall = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_priming_and_swap();
        test_degenerate_and_range();
        test_half_index_end();
        test_mode_change();
        test_register_decode();
        test_long_strip();
        test_random_strips();
        wait_idle();

        $display("Sent %0d index bytes in both widths with vertex limits from 0 to 65535.",
                 bytes_taken);
        $display("Checked %0d priming, %0d emitted, %0d degenerate, %0d out-of-range items.",
                 status_count[tsa_pkg::STATUS_PRIMING], status_count[tsa_pkg::STATUS_EMITTED],
                 status_count[tsa_pkg::STATUS_DEGENERATE],
                 status_count[tsa_pkg::STATUS_OUT_OF_RANGE]);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
